@@ design/smt_pkg.sv @@
// ----------------------------------------------------------------------------
// smt_pkg: shared types and constants of the subtitle markup tokenizer
// Holds the piece kinds, markup-mode codes, character codes and the records
// that pass between the front, the event queue and the back.
// ----------------------------------------------------------------------------
package smt_pkg;

  // Kind of a reported piece.
  typedef enum logic [1:0] {
    PK_TEXT = 2'd0,
    PK_TAG  = 2'd1,
    PK_MARK = 2'd2
  } piece_kind_t;

  // Markup mode register codes. Codes above MK_MPL2 behave like MK_NONE.
  localparam logic [2:0] MK_NONE = 3'd0;
  localparam logic [2:0] MK_HTML = 3'd1;
  localparam logic [2:0] MK_SSA  = 3'd2;
  localparam logic [2:0] MK_MDVD = 3'd3;
  localparam logic [2:0] MK_MPL2 = 3'd4;

  // Character codes.
  localparam logic [7:0] CH_LT     = 8'h3C;  // '<'
  localparam logic [7:0] CH_GT     = 8'h3E;  // '>'
  localparam logic [7:0] CH_LBRACE = 8'h7B;  // '{'
  localparam logic [7:0] CH_RBRACE = 8'h7D;  // '}'
  localparam logic [7:0] CH_NL     = 8'h0A;  // newline
  localparam logic [7:0] CH_BSLASH = 8'h5C;  // '\'
  localparam logic [7:0] CH_SLASH  = 8'h2F;  // '/'
  localparam logic [7:0] CH_UNDER  = 8'h5F;  // '_'

  // Classification of one byte, as the back needs it.
  typedef struct packed {
    logic opener;   // tag opener of the current mode
    logic closer;   // tag closer of the current mode
    logic newline;
    logic mark;     // MPL2 line-head marker character, MPL2 mode only
    logic last;     // final byte of the text
    logic ovf;      // offset bound reached at or before this byte
  } byte_class_t;

  // One result word.
  typedef struct packed {
    piece_kind_t kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        done;
    logic        blast;
    logic        ovf;
  } piece_t;

endpackage

@@ design/smt_fifo.sv @@
// ----------------------------------------------------------------------------
// smt_fifo: small synchronous queue
// Register-based first-in first-out queue with full and empty flags. The
// oldest entry is presented on dout while empty is low.
// ----------------------------------------------------------------------------
module smt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] entries_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign dout    = entries_r[rd_ptr_r];

  // Pointers wrap at the depth, which need not be a power of two.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + (AW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= din;
    end
  end

endmodule

@@ design/smt_front.sv @@
// ----------------------------------------------------------------------------
// smt_front: byte intake and classification
// Holds the markup mode register, counts byte offsets with saturation and
// classifies each accepted byte for the back.
// ----------------------------------------------------------------------------
module smt_front #(
  parameter int POS_W   = 16,
  parameter int POS_MAX = 65535
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_write_en,
  input  logic [2:0]          cfg_markup_kind,
  input  logic                accept,
  input  logic [7:0]          char_code,
  input  logic                last_char,
  output logic [POS_W-1:0]    ev_offset,
  output smt_pkg::byte_class_t ev_class
);

  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(POS_MAX);

  logic [2:0]       markup_kind_r;
  logic [POS_W-1:0] position_r, position_nxt;
  logic             overflow_r, overflow_nxt;
  logic             tags, angles, markers, at_limit;
  logic [7:0]       opener_ch, closer_ch;

  always_comb begin
    tags    = 1'b0;
    angles  = 1'b0;
    markers = 1'b0;
    unique case (markup_kind_r) inside
      smt_pkg::MK_HTML: begin
        tags   = 1'b1;
        angles = 1'b1;
      end
      smt_pkg::MK_SSA, smt_pkg::MK_MDVD: begin
        tags = 1'b1;
      end
      smt_pkg::MK_MPL2: begin
        tags    = 1'b1;
        markers = 1'b1;
      end
      default: begin
        tags = 1'b0;
      end
    endcase
  end

  assign opener_ch = angles ? smt_pkg::CH_LT : smt_pkg::CH_LBRACE;
  assign closer_ch = angles ? smt_pkg::CH_GT : smt_pkg::CH_RBRACE;
  assign at_limit  = (position_r == POS_LIMIT);

  assign ev_offset          = position_r;
  assign ev_class.opener    = tags && (char_code == opener_ch);
  assign ev_class.closer    = tags && (char_code == closer_ch);
  assign ev_class.newline   = (char_code == smt_pkg::CH_NL);
  assign ev_class.mark      = markers && ((char_code == smt_pkg::CH_BSLASH) ||
                                          (char_code == smt_pkg::CH_SLASH) ||
                                          (char_code == smt_pkg::CH_UNDER));
  assign ev_class.last      = last_char;
  assign ev_class.ovf       = overflow_r || at_limit;

  always_comb begin
    position_nxt = position_r;
    overflow_nxt = overflow_r;
    if (accept) begin
      if (last_char) begin
        position_nxt = '0;
        overflow_nxt = 1'b0;
      end else if (at_limit) begin
        overflow_nxt = 1'b1;
      end else begin
        position_nxt = position_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      markup_kind_r <= smt_pkg::MK_NONE;
      position_r    <= '0;
      overflow_r    <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        markup_kind_r <= cfg_markup_kind;
      end
      position_r <= position_nxt;
      overflow_r <= overflow_nxt;
    end
  end

endmodule

@@ design/smt_back.sv @@
// ----------------------------------------------------------------------------
// smt_back: piece builder
// Tracks open text and pending tag openers, builds up to two pieces per byte
// and hands them to the result queue one per cycle while it is not full.
// ----------------------------------------------------------------------------
module smt_back #(
  parameter int POS_W = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 ev_valid,
  input  logic [POS_W-1:0]     ev_offset,
  input  smt_pkg::byte_class_t ev_class,
  output logic                 ev_take,
  input  logic                 oq_full,
  output logic                 oq_push,
  output smt_pkg::piece_t      oq_piece
);

  localparam int LEN_W = POS_W + 1;

  logic [POS_W-1:0] text_start_r, text_start_nxt;
  logic [POS_W-1:0] tag_start_r, tag_start_nxt;
  logic             text_open_r, text_open_nxt;
  logic             tag_pending_r, tag_pending_nxt;
  logic             line_head_r, line_head_nxt;
  logic             hold_valid_r, hold_valid_nxt;
  smt_pkg::piece_t  hold_r, hold_nxt;

  smt_pkg::piece_t  pa, pb;
  logic [1:0]       n_pieces;
  logic [POS_W-1:0] off;

  // Clamp a value to the 16-bit result field.
  function automatic logic [15:0] sat16(input logic [LEN_W-1:0] v);
    logic [31:0] vx;
    vx = 32'(v);
    return (vx > 32'h0000_FFFF) ? 16'hFFFF : vx[15:0];
  endfunction

  // Bytes from a up to but not including b, at least one.
  function automatic logic [LEN_W-1:0] span_excl(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
    return (b > a) ? LEN_W'(b - a) : LEN_W'(1);
  endfunction

  // Bytes from a through b inclusive, at least one.
  function automatic logic [LEN_W-1:0] span_incl(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
    return (b > a) ? (LEN_W'(b - a) + LEN_W'(1)) : LEN_W'(1);
  endfunction

  function automatic smt_pkg::piece_t mk_piece(input smt_pkg::piece_kind_t k,
                                               input logic [POS_W-1:0] s,
                                               input logic [LEN_W-1:0] len);
    smt_pkg::piece_t p;
    p.kind   = k;
    p.start  = sat16(LEN_W'(s));
    p.length = sat16(len);
    p.done   = 1'b0;
    p.blast  = 1'b0;
    p.ovf    = 1'b0;
    return p;
  endfunction

  assign off = ev_offset;

  always_comb begin
    text_start_nxt  = text_start_r;
    tag_start_nxt   = tag_start_r;
    text_open_nxt   = text_open_r;
    tag_pending_nxt = tag_pending_r;
    line_head_nxt   = line_head_r;
    pa              = mk_piece(smt_pkg::PK_TEXT, '0, LEN_W'(1));
    pb              = pa;
    n_pieces        = 2'd0;

    if (ev_class.mark && line_head_r && !tag_pending_r) begin
      if (text_open_r) begin
        pa       = mk_piece(smt_pkg::PK_TEXT, text_start_r, span_excl(text_start_r, off));
        pb       = mk_piece(smt_pkg::PK_MARK, off, LEN_W'(1));
        n_pieces = 2'd2;
      end else begin
        pa       = mk_piece(smt_pkg::PK_MARK, off, LEN_W'(1));
        n_pieces = 2'd1;
      end
      text_open_nxt = 1'b0;
    end else begin
      line_head_nxt = ev_class.newline;
      if (tag_pending_r) begin
        if (ev_class.closer) begin
          if (text_open_r) begin
            pa = mk_piece(smt_pkg::PK_TEXT, text_start_r,
                          span_excl(text_start_r, tag_start_r));
            pb = mk_piece(smt_pkg::PK_TAG, tag_start_r, span_incl(tag_start_r, off));
            n_pieces = 2'd2;
          end else begin
            pa = mk_piece(smt_pkg::PK_TAG, tag_start_r, span_incl(tag_start_r, off));
            n_pieces = 2'd1;
          end
          text_open_nxt   = 1'b0;
          tag_pending_nxt = 1'b0;
        end else if (ev_class.newline || ev_class.opener) begin
          // The pending opener failed and joins the text.
          if (!text_open_r) begin
            text_open_nxt  = 1'b1;
            text_start_nxt = tag_start_r;
          end
          tag_pending_nxt = ev_class.opener;
          if (ev_class.opener) begin
            tag_start_nxt = off;
          end
        end
      end else if (ev_class.opener) begin
        tag_pending_nxt = 1'b1;
        tag_start_nxt   = off;
      end else if (!text_open_r) begin
        text_open_nxt  = 1'b1;
        text_start_nxt = off;
      end
    end

    // End of text: flush whatever text is open, a pending opener included, then
    // start over. A closing text piece here is always the only piece of its byte.
    if (ev_class.last) begin
      if (tag_pending_nxt && !text_open_nxt) begin
        text_open_nxt  = 1'b1;
        text_start_nxt = tag_start_nxt;
      end
      if (text_open_nxt) begin
        pa = mk_piece(smt_pkg::PK_TEXT, text_start_nxt, span_incl(text_start_nxt, off));
        n_pieces = 2'd1;
      end
      text_start_nxt  = '0;
      tag_start_nxt   = '0;
      text_open_nxt   = 1'b0;
      tag_pending_nxt = 1'b0;
      line_head_nxt   = 1'b1;
    end

    pa.ovf = ev_class.ovf;
    pb.ovf = ev_class.ovf;
    if (n_pieces == 2'd1) begin
      pa.blast = 1'b1;
      pa.done  = ev_class.last;
    end
    pb.blast = 1'b1;
    pb.done  = ev_class.last;
  end

  // A held second piece goes out before the next byte is taken.
  always_comb begin
    ev_take        = 1'b0;
    oq_push        = 1'b0;
    oq_piece       = pa;
    hold_valid_nxt = hold_valid_r;
    hold_nxt       = hold_r;
    if (hold_valid_r) begin
      oq_piece = hold_r;
      if (!oq_full) begin
        oq_push        = 1'b1;
        hold_valid_nxt = 1'b0;
      end
    end else if (ev_valid && !oq_full) begin
      ev_take = 1'b1;
      oq_push = (n_pieces != 2'd0);
      if (n_pieces == 2'd2) begin
        hold_valid_nxt = 1'b1;
        hold_nxt       = pb;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_start_r  <= '0;
      tag_start_r   <= '0;
      text_open_r   <= 1'b0;
      tag_pending_r <= 1'b0;
      line_head_r   <= 1'b1;
      hold_valid_r  <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      if (ev_take) begin
        text_start_r  <= text_start_nxt;
        tag_start_r   <= tag_start_nxt;
        text_open_r   <= text_open_nxt;
        tag_pending_r <= tag_pending_nxt;
        line_head_r   <= line_head_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
  end

endmodule

@@ design/subtitle_markup_tokenizer_core.sv @@
// ----------------------------------------------------------------------------
// subtitle_markup_tokenizer_core: subtitle markup tokenizer
// Splits subtitle text, one byte per word, into tag, MPL2 marker and text
// pieces, each reported with its kind, start offset and length.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake          Payload
//   -------   ----------------   -------------------------------------------
//   input     push / full        in_char_code, in_last_char
//   result    pop / empty        out_piece_kind, out_piece_start,
//                                out_piece_length, out_text_done,
//                                out_batch_last, out_overflow
//   config    cfg_write_en       cfg_markup_kind
//
// An accepted byte enters the event queue in the same cycle, and the back
// turns it into pieces at the queue head. The rate is one byte per cycle
// while the result queue is not full; a byte that gives two pieces holds the
// back until its second piece is pushed, as the result queue takes one word
// per cycle. Reset is synchronous and leaves both queues empty with no text
// open and the mode set to none. Either side may stall freely: a full result
// queue stalls the back, and the event queue then fills and raises full.
//
module subtitle_markup_tokenizer_core #(
  parameter int MAX_TEXT_LENGTH = 65535
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_char_code,
  input  logic        in_last_char,

  input  logic        pop,
  output logic        empty,
  output logic [1:0]  out_piece_kind,
  output logic [15:0] out_piece_start,
  output logic [15:0] out_piece_length,
  output logic        out_text_done,
  output logic        out_batch_last,
  output logic        out_overflow,

  input  logic        cfg_write_en,
  input  logic [2:0]  cfg_markup_kind
);

  // Offsets run from zero up to MAX_TEXT_LENGTH and then stick there.
  localparam int POS_W    = $clog2(MAX_TEXT_LENGTH + 1);
  localparam int EV_W     = POS_W + $bits(smt_pkg::byte_class_t);
  localparam int PIECE_W  = $bits(smt_pkg::piece_t);
  localparam int EVQ_DEPTH = 4;
  localparam int OUTQ_DEPTH = 4;

  logic                 in_accept;
  logic [POS_W-1:0]     fr_offset;
  smt_pkg::byte_class_t fr_class;

  logic                 evq_empty;
  logic [EV_W-1:0]      evq_dout;
  logic [POS_W-1:0]     bk_offset;
  smt_pkg::byte_class_t bk_class;
  logic                 bk_take;

  logic                 oq_full;
  logic                 oq_push;
  smt_pkg::piece_t      oq_piece;
  smt_pkg::piece_t      out_word;

  assign in_accept = push & ~full;

  // Front: mode register, offset counter and byte classification.
  smt_front #(
    .POS_W   (POS_W),
    .POS_MAX (MAX_TEXT_LENGTH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_write_en    (cfg_write_en),
    .cfg_markup_kind (cfg_markup_kind),
    .accept          (in_accept),
    .char_code       (in_char_code),
    .last_char       (in_last_char),
    .ev_offset       (fr_offset),
    .ev_class        (fr_class)
  );

  // Event queue between the front and the back; its full flag is the
  // block's input back-pressure.
  smt_fifo #(
    .WIDTH (EV_W),
    .DEPTH (EVQ_DEPTH)
  ) u_evq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   ({fr_offset, fr_class}),
    .full  (full),
    .pop   (bk_take),
    .dout  (evq_dout),
    .empty (evq_empty)
  );

  assign bk_offset = evq_dout[EV_W-1 -: POS_W];
  assign bk_class  = smt_pkg::byte_class_t'(evq_dout[EV_W-POS_W-1:0]);

  // Back: text and tag tracking, piece assembly.
  smt_back #(
    .POS_W (POS_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev_valid  (~evq_empty),
    .ev_offset (bk_offset),
    .ev_class  (bk_class),
    .ev_take   (bk_take),
    .oq_full   (oq_full),
    .oq_push   (oq_push),
    .oq_piece  (oq_piece)
  );

  // Result queue, presented on the output ports while not empty.
  smt_fifo #(
    .WIDTH (PIECE_W),
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .din   (oq_piece),
    .full  (oq_full),
    .pop   (pop),
    .dout  (out_word),
    .empty (empty)
  );

  assign out_piece_kind   = out_word.kind;
  assign out_piece_start  = out_word.start;
  assign out_piece_length = out_word.length;
  assign out_text_done    = out_word.done;
  assign out_batch_last   = out_word.blast;
  assign out_overflow     = out_word.ovf;

endmodule
